/* hdl/spq_pkg.sv */
// Shared types and command codes for the sorted priority queue.
package spq_pkg;

    // Command codes carried in the low bits of the input beat.
    localparam logic [1:0] CMD_PEEK = 2'd0;
    localparam logic [1:0] CMD_PUSH = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;

    // Widths of the packed stream beats, padded to whole bytes.
    localparam int IN_W  = 56;
    localparam int OUT_W = 56;

    // One stored entry: data handle and signed priority.
    typedef struct packed {
        logic        [31:0] data;
        logic signed [15:0] prio;
    } entry_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

/* hdl/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts it left or right.
module spq_cell (
    input  logic                aclk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                left_less,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    output logic                less,
    output spq_pkg::entry_t     entry_q,
    output spq_pkg::entry_t     entry_d
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // A stored entry that sorts strictly before the new one stays in place on a push.
    assign less = occupied && (entry_reg.prio < ctrl.new_entry.prio);

    // Insertion takes the new entry at the first slot that is not less,
    // the slots behind it take their left neighbour; a pop shifts everything left.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.push) begin
            if (less) begin
                entry_next = entry_reg;
            end else if (left_less) begin
                entry_next = ctrl.new_entry;
            end else begin
                entry_next = left_entry;
            end
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    // Entry storage carries no reset; only slots below the count are ever read.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;
    assign entry_d = entry_next;

endmodule

/* hdl/sorted_priority_queue.sv */
// Top level of the sorted priority queue built as a chain of slot cells.
// Every beat is processed in the cycle it is accepted; its result beat is
// valid on the next cycle, and the parallel compare and shift across all cells
// lets one beat be taken per cycle while the result register is free or drained.
// aresetn (synchronous, active low) empties the queue and drops any pending
// result beat; entry contents are not cleared.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata fields from bit 0: cmd[1:0], item_data[33:2], priority_req[49:34]
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [spq_pkg::IN_W-1:0]    s_tdata,
    // m_tdata fields from bit 0: head_data[31:0], head_priority[47:32],
    // is_empty[48], is_full[49], rejected[50], occupancy[55:51]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [spq_pkg::OUT_W-1:0]   m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [spq_pkg::OUT_W-1:0] m_tdata_reg;
    logic [spq_pkg::OUT_W-1:0] m_tdata_next;

    logic                    s_fire;
    logic [1:0]              cmd;
    logic                    full;
    logic                    empty;
    logic                    do_push;
    logic                    do_pop;
    logic                    rejected;
    spq_pkg::cell_ctrl_t     ctrl;

    logic [CAPACITY-1:0]     occupied;
    logic [CAPACITY-1:0]     less;
    spq_pkg::entry_t         entry_q [CAPACITY];
    spq_pkg::entry_t         entry_d [CAPACITY];

    spq_pkg::entry_t         head;
    logic [CNT_W+4:0]        occ_ext;

    // A new beat is taken whenever the output register is free or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign cmd      = s_tdata[1:0];

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // Decode the operation; a push when full and a pop when empty are ignored.
    always_comb begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        rejected = 1'b0;
        if (s_fire) begin
            unique case (cmd)
                spq_pkg::CMD_PUSH: begin
                    do_push  = !full;
                    rejected = full;
                end
                spq_pkg::CMD_POP: begin
                    do_pop   = !empty;
                    rejected = empty;
                end
                default: begin
                end
            endcase
        end
    end

    assign ctrl.push           = do_push;
    assign ctrl.pop            = do_pop;
    assign ctrl.new_entry.data = s_tdata[33:2];
    assign ctrl.new_entry.prio = s_tdata[49:34];

    // The chain of slots, head at index 0.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic            left_less;
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;

        assign occupied[i] = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_first
            assign left_less  = 1'b1;
            assign left_entry = ctrl.new_entry;
        end else begin : g_inner
            assign left_less  = less[i-1];
            assign left_entry = entry_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = entry_q[i];
        end else begin : g_body
            assign right_entry = entry_q[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (occupied[i]),
            .left_less   (left_less),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .less        (less[i]),
            .entry_q     (entry_q[i]),
            .entry_d     (entry_d[i])
        );
    end

    // Occupancy after the step.
    always_comb begin
        count_next = count_reg;
        if (do_push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Result beat describes the queue after the step.
    assign head    = entry_d[0];
    assign occ_ext = {5'd0, count_next};

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (s_fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            if (count_next != '0) begin
                m_tdata_next[31:0]  = head.data;
                m_tdata_next[47:32] = head.prio;
            end
            m_tdata_next[48]    = (count_next == '0);
            m_tdata_next[49]    = (count_next == CNT_W'(CAPACITY));
            m_tdata_next[50]    = rejected;
            m_tdata_next[55:51] = occ_ext[4:0];
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Count and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The count never exceeds the number of slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // An accepted push into a queue with room grows it by one.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && cmd == spq_pkg::CMD_PUSH && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not add an entry");

    // The pending result always reports the current occupancy.
    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[55:51] == occ_ext[4:0] || s_fire)
                      || (m_tdata_reg[55:51] == 5'(count_reg)))
        else $error("result occupancy disagrees with the count");

    // The two front slots stay in ascending priority order.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (entry_q[0].prio <= entry_q[1].prio))
        else $error("head slots out of order");
`endif

endmodule
